FILE: rtl/dqs_pkg.sv
package dqs_pkg;

   // Geometry of the ring and of the stored words
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int IDX_W      = PTR_W + 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Port field widths
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 32;
   localparam int POS_W    = 5;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ_ALL   = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   // Result of the shared compare unit
   typedef struct packed {
      logic             match;
      logic [OUT_W-1:0] value;
   } cmp_result_type;

   // Ring slot of the element at offset idx from the front (idx <= DEPTH)
   function automatic ptr_type slot_index(ptr_type front, idx_type idx);
      logic [IDX_W:0] sum;
      sum = (IDX_W + 1)'(front) + (IDX_W + 1)'(idx);
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return PTR_W'(sum);
   endfunction

endpackage

FILE: rtl/dqs_ram.sv
module dqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/dqs_cmp.sv
module dqs_cmp (
   input  dqs_pkg::word_type       rd_word,
   input  dqs_pkg::word_type       key,
   output dqs_pkg::cmp_result_type result
);

   logic [63:0] word_ext;

   // Compare the stored word against the key and sign-extend it to the output width
   always_comb begin
      word_ext     = 64'(signed'(rd_word));
      result.match = (rd_word == key);
      result.value = word_ext[dqs_pkg::OUT_W-1:0];
   end

endmodule

FILE: rtl/deque_with_search_core.sv
// Bounded double-ended queue with search, kept as a ring in a small RAM.
// Command channel: drive req_mode and req_value with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Modes: push front/back, pop front/back, search, read out all.
// Result channel: each result sits on the rsp_ ports for one cycle, marked
// by rsp_strobe; rsp_last flags the final result of a command. The receiver
// cannot stall, so results must be taken as they appear.
// Push and any command hitting an empty or full queue answer in the cycle
// after acceptance and leave busy low. A pop reads the RAM when accepted and
// answers from the registered read data. Search and read-out walk the stored
// entries through the single RAM read port and the shared compare unit, one
// entry per cycle. Read-out streams one result per cycle after the first.
// Reset (synchronous, active high) empties the queue and returns to idle;
// the RAM contents are not cleared, since only occupied entries are read.
module deque_with_search_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dqs_pkg::MODE_W-1:0]     req_mode,
   input  logic signed [31:0]             req_value,
   output logic                           rsp_strobe,
   output logic [dqs_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed [dqs_pkg::OUT_W-1:0] rsp_data_out,
   output logic [dqs_pkg::POS_W-1:0]      rsp_position,
   output logic [dqs_pkg::POS_W-1:0]      rsp_occupancy,
   output logic                           rsp_last
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_POP    = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_DUMP   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   dqs_pkg::ptr_type            front_ff, front_in;
   dqs_pkg::cnt_type            count_ff, count_in;
   dqs_pkg::ptr_type            walk_ff, walk_in;
   dqs_pkg::word_type           key_ff, key_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [dqs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [dqs_pkg::OUT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [dqs_pkg::POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [dqs_pkg::POS_W-1:0]   rsp_occupancy_ff, rsp_occupancy_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept;
   logic                        is_full;
   logic                        is_empty;
   logic                        at_end;
   dqs_pkg::idx_type            walk_next;
   dqs_pkg::idx_type            count_idx;
   logic [63:0]                 value_ext;
   dqs_pkg::word_type           value_word;

   logic                        wr_en;
   dqs_pkg::ptr_type            wr_addr;
   dqs_pkg::ptr_type            rd_addr;
   dqs_pkg::word_type           rd_word;
   dqs_pkg::cmp_result_type     cmp_result;

   dqs_ram #(
      .WIDTH (dqs_pkg::DATA_WIDTH),
      .DEPTH (dqs_pkg::DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   dqs_cmp u_cmp (
      .rd_word (rd_word),
      .key     (key_ff),
      .result  (cmp_result)
   );

   assign busy          = (state_ff != S_IDLE);
   assign accept        = start && !busy;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_last      = rsp_last_ff;

   // Decode queue level and walk position
   always_comb begin
      value_ext  = 64'(signed'(req_value));
      value_word = value_ext[dqs_pkg::DATA_WIDTH-1:0];
      is_full    = (count_ff >= dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
      is_empty   = (count_ff == '0);
      count_idx  = dqs_pkg::IDX_W'(count_ff);
      walk_next  = dqs_pkg::IDX_W'(walk_ff) + dqs_pkg::IDX_W'(1);
      at_end     = (walk_next == count_idx);
   end

   // Sequence commands and drive the RAM ports
   always_comb begin
      state_in         = state_ff;
      front_in         = front_ff;
      count_in         = count_ff;
      walk_in          = walk_ff;
      key_in           = key_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rsp_last_in      = rsp_last_ff;
      wr_en            = 1'b0;
      wr_addr          = dqs_pkg::slot_index(front_ff, count_idx);
      rd_addr          = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in           = value_word;
               walk_in          = '0;
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = dqs_pkg::STATUS_OK;
               rsp_data_in      = '0;
               rsp_position_in  = '0;
               rsp_occupancy_in = dqs_pkg::POS_W'(count_ff);
               rsp_last_in      = 1'b1;
               unique case (req_mode)
                  dqs_pkg::MODE_PUSH_FRONT, dqs_pkg::MODE_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = dqs_pkg::STATUS_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        count_in         = count_ff + dqs_pkg::CNT_W'(1);
                        rsp_occupancy_in = dqs_pkg::POS_W'(count_in);
                        if (req_mode == dqs_pkg::MODE_PUSH_FRONT) begin
                           front_in = (front_ff == '0)
                                    ? dqs_pkg::PTR_W'(dqs_pkg::DEPTH - 1)
                                    : front_ff - dqs_pkg::PTR_W'(1);
                           wr_addr  = front_in;
                        end
                     end
                  end
                  dqs_pkg::MODE_POP_FRONT, dqs_pkg::MODE_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = dqs_pkg::STATUS_EMPTY;
                     end else begin
                        // Read the element now, report it from S_POP
                        rsp_strobe_in = 1'b0;
                        count_in      = count_ff - dqs_pkg::CNT_W'(1);
                        state_in      = S_POP;
                        if (req_mode == dqs_pkg::MODE_POP_FRONT) begin
                           front_in = dqs_pkg::slot_index(front_ff,
                                                          dqs_pkg::IDX_W'(1));
                        end else begin
                           rd_addr  = dqs_pkg::slot_index(front_ff,
                                         count_idx - dqs_pkg::IDX_W'(1));
                        end
                     end
                  end
                  dqs_pkg::MODE_SEARCH, dqs_pkg::MODE_READ_ALL: begin
                     if (is_empty) begin
                        rsp_status_in = dqs_pkg::STATUS_EMPTY;
                     end else begin
                        // Fetch the front entry and start the walk
                        rsp_strobe_in = 1'b0;
                        state_in      = (req_mode == dqs_pkg::MODE_SEARCH)
                                      ? S_SEARCH : S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_strobe_in    = 1'b1;
            rsp_status_in    = dqs_pkg::STATUS_OK;
            rsp_data_in      = cmp_result.value;
            rsp_position_in  = '0;
            rsp_occupancy_in = dqs_pkg::POS_W'(count_ff);
            rsp_last_in      = 1'b1;
            state_in         = S_IDLE;
         end
         S_SEARCH: begin
            rd_addr          = dqs_pkg::slot_index(front_ff, walk_next);
            walk_in          = dqs_pkg::PTR_W'(walk_next);
            rsp_data_in      = '0;
            rsp_occupancy_in = dqs_pkg::POS_W'(count_ff);
            rsp_last_in      = 1'b1;
            if (cmp_result.match) begin
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = dqs_pkg::STATUS_OK;
               rsp_position_in = dqs_pkg::POS_W'(walk_next);
               state_in        = S_IDLE;
            end else if (at_end) begin
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = dqs_pkg::STATUS_NOTFOUND;
               rsp_position_in = '0;
               state_in        = S_IDLE;
            end
         end
         S_DUMP: begin
            rd_addr          = dqs_pkg::slot_index(front_ff, walk_next);
            walk_in          = dqs_pkg::PTR_W'(walk_next);
            rsp_strobe_in    = 1'b1;
            rsp_status_in    = dqs_pkg::STATUS_OK;
            rsp_data_in      = cmp_result.value;
            rsp_position_in  = '0;
            rsp_occupancy_in = dqs_pkg::POS_W'(count_ff);
            rsp_last_in      = at_end;
            if (at_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state, clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Advance the walk and result payload
   always_ff @(posedge clock) begin
      walk_ff          <= walk_in;
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // An accepted transaction either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe_ff || busy))
      else $error("accepted transaction neither answered nor in progress");

   // Only read-out produces results that are not last, and it stays busy
   a_stream_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_last_ff) |-> (state_ff == S_DUMP))
      else $error("non-final result outside read-out");

   // The element count never exceeds the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
      else $error("element count beyond depth");

   // The front pointer stays inside the ring
   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      dqs_pkg::IDX_W'(front_ff) < dqs_pkg::IDX_W'(dqs_pkg::DEPTH))
      else $error("front pointer outside ring");

   // The walk never passes the occupied region
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_DUMP) |->
         (dqs_pkg::IDX_W'(walk_ff) < count_idx))
      else $error("walk index beyond element count");

endmodule

FILE: verif/deque_with_search_checker.sv
`timescale 1ns / 100ps

module deque_with_search_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [dqs_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [31:0]                req_value,
   input  logic                              rsp_strobe,
   input  logic [dqs_pkg::STATUS_W-1:0]      rsp_status,
   input  logic signed [dqs_pkg::OUT_W-1:0]  rsp_data_out,
   input  logic [dqs_pkg::POS_W-1:0]         rsp_position,
   input  logic [dqs_pkg::POS_W-1:0]         rsp_occupancy,
   input  logic                              rsp_last,
   output int                                mismatch_count,
   output int                                answers_pending
);

   // One expected result transaction
   typedef struct {
      logic [dqs_pkg::STATUS_W-1:0] status;
      logic [dqs_pkg::OUT_W-1:0]    data;
      logic [dqs_pkg::POS_W-1:0]    position;
      logic [dqs_pkg::POS_W-1:0]    occupancy;
      logic                         last;
   } deque_answer_type;

   // Shadow copy of the ring, its front slot and its element count
   dqs_pkg::word_type ring [dqs_pkg::DEPTH];
   dqs_pkg::ptr_type  head;
   int                held;
   deque_answer_type  answers_due [$];
   int                errors = 0;

   assign mismatch_count = errors;

   task automatic report_mismatch(input string what);
      if (errors < 40) begin
         $display("%0t: deque result error: %s", $time, what);
      end
      errors++;
   endtask

   // Ring slot of the element at the given distance from the front
   function automatic dqs_pkg::ptr_type ring_slot(input int offset);
      return dqs_pkg::ptr_type'((int'(head) + offset) % dqs_pkg::DEPTH);
   endfunction

   // Sign-extend a stored word to the output width
   function automatic logic [dqs_pkg::OUT_W-1:0] widen(input dqs_pkg::word_type w);
      logic signed [dqs_pkg::DATA_WIDTH-1:0] s;
      s = w;
      return dqs_pkg::OUT_W'(s);
   endfunction

   task automatic post_answer(input logic [dqs_pkg::STATUS_W-1:0] status,
                              input logic [dqs_pkg::OUT_W-1:0] data,
                              input int position, input logic last);
      deque_answer_type ans;
      ans.status    = status;
      ans.data      = data;
      ans.position  = dqs_pkg::POS_W'(position);
      ans.occupancy = dqs_pkg::POS_W'(held);
      ans.last      = last;
      answers_due.push_back(ans);
   endtask

   // Apply one accepted command to the shadow queue and queue its results
   task automatic predict_command(input logic [dqs_pkg::MODE_W-1:0] mode,
                                  input logic [31:0] value);
      dqs_pkg::word_type key;
      dqs_pkg::word_type taken;
      int                hit;
      key = dqs_pkg::word_type'(value);
      hit = 0;
      case (mode)
         dqs_pkg::MODE_PUSH_FRONT, dqs_pkg::MODE_PUSH_BACK: begin
            if (held == dqs_pkg::DEPTH) begin
               post_answer(dqs_pkg::STATUS_FULL, '0, 0, 1'b1);
            end else begin
               if (mode == dqs_pkg::MODE_PUSH_FRONT) begin
                  head = ring_slot(dqs_pkg::DEPTH - 1);
                  ring[head] = key;
               end else begin
                  ring[ring_slot(held)] = key;
               end
               held++;
               post_answer(dqs_pkg::STATUS_OK, '0, 0, 1'b1);
            end
         end
         dqs_pkg::MODE_POP_FRONT, dqs_pkg::MODE_POP_BACK: begin
            if (held == 0) begin
               post_answer(dqs_pkg::STATUS_EMPTY, '0, 0, 1'b1);
            end else begin
               if (mode == dqs_pkg::MODE_POP_FRONT) begin
                  taken = ring[head];
                  head = ring_slot(1);
               end else begin
                  taken = ring[ring_slot(held - 1)];
               end
               held--;
               post_answer(dqs_pkg::STATUS_OK, widen(taken), 0, 1'b1);
            end
         end
         dqs_pkg::MODE_SEARCH: begin
            if (held == 0) begin
               post_answer(dqs_pkg::STATUS_EMPTY, '0, 0, 1'b1);
            end else begin
               // first match from the front, including the final element
               for (int i = 0; i < held; i++) begin
                  if (hit == 0 && ring[ring_slot(i)] == key) hit = i + 1;
               end
               if (hit != 0) post_answer(dqs_pkg::STATUS_OK, '0, hit, 1'b1);
               else post_answer(dqs_pkg::STATUS_NOTFOUND, '0, 0, 1'b1);
            end
         end
         dqs_pkg::MODE_READ_ALL: begin
            if (held == 0) begin
               post_answer(dqs_pkg::STATUS_EMPTY, '0, 0, 1'b1);
            end else begin
               for (int i = 0; i < held; i++) begin
                  post_answer(dqs_pkg::STATUS_OK, widen(ring[ring_slot(i)]), 0,
                              i == held - 1);
               end
            end
         end
         default: begin
            post_answer(dqs_pkg::STATUS_OK, '0, 0, 1'b1);
         end
      endcase
   endtask

   // Compare one result transaction with the oldest expectation
   task automatic check_answer();
      deque_answer_type due;
      if (rsp_strobe !== 1'b1) begin
         report_mismatch("result strobe is unknown");
         return;
      end
      if (answers_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result, status %0d data %0h", rsp_status,
                                   rsp_data_out));
         return;
      end
      due = answers_due.pop_front();
      if (rsp_status !== due.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_status, due.status));
      if (rsp_data_out !== due.data)
         report_mismatch($sformatf("data_out %0h, expected %0h", rsp_data_out, due.data));
      if (rsp_position !== due.position)
         report_mismatch($sformatf("position %0d, expected %0d", rsp_position, due.position));
      if (rsp_occupancy !== due.occupancy)
         report_mismatch($sformatf("occupancy %0d, expected %0d", rsp_occupancy,
                                   due.occupancy));
      if (rsp_last !== due.last)
         report_mismatch($sformatf("last %0b, expected %0b", rsp_last, due.last));
   endtask

   // Check results first, then predict for a command taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         head = '0;
         held = 0;
         answers_due.delete();
      end else begin
         if (rsp_strobe !== 1'b0) check_answer();
         if (start === 1'b1 && busy === 1'b0) predict_command(req_mode, req_value);
      end
      answers_pending <= answers_due.size();
   end

endmodule

FILE: verif/deque_with_search_core_tb.sv
`timescale 1ns / 100ps

module deque_with_search_core_tb;

   localparam int RANDOM_COMMANDS = 170;
   localparam int QUIET_TAIL      = 30;

   // Codes that the block treats as no operation
   localparam logic [dqs_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [dqs_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef enum int {PHASE_FILL, PHASE_MIXED, PHASE_DRAIN} phase_kind_type;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [dqs_pkg::MODE_W-1:0]         req_mode;
   logic signed [31:0]                 req_value;
   logic                               rsp_strobe;
   logic [dqs_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [dqs_pkg::OUT_W-1:0]   rsp_data_out;
   logic [dqs_pkg::POS_W-1:0]          rsp_position;
   logic [dqs_pkg::POS_W-1:0]          rsp_occupancy;
   logic                               rsp_last;
   int                                 mismatch_count;
   int                                 answers_pending;

   logic signed [31:0] key_pool [$];
   logic signed [31:0] corners [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1};

   deque_with_search_core DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_data_out  (rsp_data_out),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

   deque_with_search_checker deque_watch (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_position    (rsp_position),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Present one command and hold it until the block takes it
   task automatic send_command(input logic [dqs_pkg::MODE_W-1:0] mode,
                               input logic signed [31:0] value);
      @(negedge clock);
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      if (mode == dqs_pkg::MODE_PUSH_FRONT || mode == dqs_pkg::MODE_PUSH_BACK) begin
         key_pool.push_back(value);
         if (key_pool.size() > 24) void'(key_pool.pop_front());
      end
   endtask

   // Drop start and drive noise on the command fields
   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start     <= 1'b0;
         req_mode  <= dqs_pkg::MODE_W'($urandom());
         req_value <= $urandom();
      end
   endtask

   // Mode mix leans toward pushes or pops depending on the phase
   function automatic logic [dqs_pkg::MODE_W-1:0] pick_mode(input phase_kind_type kind);
      int roll;
      int push_pct;
      int pop_pct;
      roll = $urandom_range(0, 99);
      if (roll < 3) return (roll == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      case (kind)
         PHASE_FILL: begin
            push_pct = 75;
            pop_pct  = 10;
         end
         PHASE_DRAIN: begin
            push_pct = 15;
            pop_pct  = 65;
         end
         default: begin
            push_pct = 40;
            pop_pct  = 35;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return $urandom_range(0, 1) ? dqs_pkg::MODE_PUSH_BACK : dqs_pkg::MODE_PUSH_FRONT;
      if (roll < push_pct + pop_pct)
         return $urandom_range(0, 1) ? dqs_pkg::MODE_POP_BACK : dqs_pkg::MODE_POP_FRONT;
      if (roll < 92) return dqs_pkg::MODE_SEARCH;
      return dqs_pkg::MODE_READ_ALL;
   endfunction

   // Reuse recent values so searches hit and pushes make duplicates
   function automatic logic signed [31:0] pick_value(input logic [dqs_pkg::MODE_W-1:0] mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (key_pool.size() > 0 && roll < ((mode == dqs_pkg::MODE_SEARCH) ? 60 : 25))
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (roll > 89) return corners[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   initial begin
      int                          sent;
      int                          phase;
      int                          run_len;
      bit                          idle_on;
      logic [dqs_pkg::MODE_W-1:0]  mode;
      phase_kind_type              kind;

      reset     = 1'b1;
      start     = 1'b0;
      req_mode  = dqs_pkg::MODE_PUSH_FRONT;
      req_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Pops, search and read-out on an empty queue, then the unused codes
      send_command(dqs_pkg::MODE_POP_FRONT, 32'sd17);
      send_command(dqs_pkg::MODE_POP_BACK, -32'sd17);
      send_command(dqs_pkg::MODE_SEARCH, 32'sd0);
      send_command(dqs_pkg::MODE_READ_ALL, 32'sd0);
      send_command(MODE_SPARE_6, 32'sh5A5A_A5A5);
      send_command(MODE_SPARE_7, -32'sd1);

      // Extremes at both ends, front pushes wrap the ring below slot zero
      send_command(dqs_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
      send_command(dqs_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF);
      send_command(dqs_pkg::MODE_PUSH_FRONT, -32'sd1);
      send_command(dqs_pkg::MODE_PUSH_BACK, 32'sd0);
      send_command(dqs_pkg::MODE_PUSH_BACK, -32'sd1);

      // Match next to the back, first of two duplicates, and a miss
      send_command(dqs_pkg::MODE_SEARCH, 32'sd0);
      send_command(dqs_pkg::MODE_SEARCH, -32'sd1);
      send_command(dqs_pkg::MODE_SEARCH, 32'sd12345);
      send_command(dqs_pkg::MODE_READ_ALL, 32'sd0);
      send_command(dqs_pkg::MODE_POP_BACK, 32'sd0);
      send_command(dqs_pkg::MODE_POP_FRONT, 32'sd0);
      send_command(dqs_pkg::MODE_READ_ALL, 32'sd0);

      // Random phases that fill, churn and drain the queue
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_COMMANDS) begin
         kind    = phase_kind_type'(phase % 3);
         run_len = $urandom_range(18, 32);
         idle_on = $urandom_range(0, 2) != 0;
         phase++;
         for (int k = 0; k < run_len && sent < RANDOM_COMMANDS; k++) begin
            mode = pick_mode(kind);
            send_command(mode, pick_value(mode));
            sent++;
            if (idle_on && sent < RANDOM_COMMANDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
               hold_off($urandom_range(1, 15));
         end
      end

      // Drain outstanding results, then allow for a full walk of the ring
      @(negedge clock);
      start <= 1'b0;
      wait (answers_pending == 0);
      repeat (2 * dqs_pkg::DEPTH + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: deque_with_search_core.f
rtl/dqs_pkg.sv
rtl/dqs_ram.sv
rtl/dqs_cmp.sv
rtl/deque_with_search_core.sv
verif/deque_with_search_checker.sv
verif/deque_with_search_core_tb.sv
